// ----- design/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms used by the migration rate matrix RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- design/mcrm_pkg.sv -----
// ----------------------------------------------------------------------------
// mcrm_pkg
// Types, constants and command structures of the migration rate matrix.
// ----------------------------------------------------------------------------
`default_nettype none

package mcrm_pkg;

  // Number of populations and derived index widths.
  localparam int POPULATIONS = 4;
  localparam int IW          = $clog2(POPULATIONS);
  localparam int ADDR_W      = 2 * IW;
  localparam int MEM_DEPTH   = 1 << ADDR_W;
  localparam int SUM_W       = 32 + IW;

  // Fixed-point constants.
  localparam logic [31:0]      PROB_ONE     = 32'h8000_0000;
  localparam logic [31:0]      PROB_DEFAULT = 32'd2147484;
  localparam logic [31:0]      SIZE_DEFAULT = 32'd100000;
  localparam logic [47:0]      MAX48        = 48'hFFFF_FFFF_FFFF;
  localparam logic [SUM_W-1:0] SUM_ONE      = SUM_W'(PROB_ONE);

  // Request opcodes.
  localparam logic [1:0] OP_LOAD_PROB = 2'd0;
  localparam logic [1:0] OP_LOAD_POP  = 2'd1;
  localparam logic [1:0] OP_COMPUTE   = 2'd2;

  typedef logic [IW-1:0] idx_t;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [1:0]  source_index;
    logic [1:0]  target_index;
    logic [31:0] probability;
    logic [31:0] pop_size;
    logic [31:0] contact_density;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  row_index;
    logic [1:0]  column_index;
    logic [47:0] effective_rate;
    logic [47:0] multiplier_rate;
    logic [47:0] actual_size_of_target;
    logic [47:0] max_effective_of_target;
    logic        fault;
    logic        last;
  } out_item_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_DG_RD,
    ST_DG_ACC,
    ST_DG_WR,
    ST_MX_RD,
    ST_MX_MUL,
    ST_MX_ACC,
    ST_MX_ST,
    ST_PAIR,
    ST_PAIR_END,
    ST_TM_CHK,
    ST_TM_RD1,
    ST_TM_RD2,
    ST_TM_PP,
    ST_TM_LO,
    ST_TM_HI,
    ST_TM_NUM,
    ST_TM_DST,
    ST_TM_DWAIT,
    ST_TM_ACC,
    ST_TM_NEXT,
    ST_EMIT,
    ST_PAIR_NEXT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_prob;
    logic load_pop;
    logic run_start;
    logic rd_en;
    idx_t row;
    idx_t col;
    idx_t k;
    logic sum_add;
    logic diag_write;
    logic mul_size;
    logic acc_mix;
    logic store_mix;
    logic capture_a;
    logic mul_pp;
    logic mul_lo;
    logic mul_hi;
    logic form_num;
    logic div_start;
    logic acc_term;
    logic max_update;
    logic hold_eff;
    logic acc_clear;
    logic emit;
    logic last;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic mixed_zero;
    logic div_done;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

// ----- design/migration_contact_rate_matrix.sv -----
// ----------------------------------------------------------------------------
// migration_contact_rate_matrix
// Migration probability matrix with effective and multiplier contact rates.
// ----------------------------------------------------------------------------
// Load requests (probability or population record) are taken one per cycle
// and produce no result. A compute request first runs the diagonal and
// mixed-size passes; every rate term then uses the 48-step restoring
// divider that divides by the mixed size. Effective rates are computed
// once to find each target's maximum and again while results are
// delivered, N^2 results in source-major order, the last one flagged. No
// request is accepted until a compute has placed its final result in the
// output register; that result may still be waiting there when the next
// request is taken.
`default_nettype none

module migration_contact_rate_matrix (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire mcrm_pkg::in_item_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output mcrm_pkg::out_item_t      out_data
);

  mcrm_pkg::cmd_t cmd;
  mcrm_pkg::sts_t sts;

  mcrm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .opcode   (in_data.opcode),
    .in_ready (in_ready),
    .cmd      (cmd),
    .sts      (sts)
  );

  mcrm_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

// ----- design/mcrm_div.sv -----
// ----------------------------------------------------------------------------
// mcrm_div
// Restoring divider, one quotient bit per cycle, quotient saturated to 48 bits.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module mcrm_div (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [65:0] numer,
  input  wire logic [47:0] denom,
  output logic             done,
  output logic [47:0]      quot
);

  logic        busy;
  logic [5:0]  cnt;
  logic [47:0] rem;
  logic [47:0] nlo;
  logic [47:0] dreg;
  logic [48:0] trial;
  logic        fits;
  logic        sat;

  // A quotient of 2^48 or more shows up as the top bits already reaching the divisor.
  assign sat   = {30'b0, numer[65:48]} >= denom;
  assign trial = {rem, nlo[47]};
  assign fits  = trial >= {1'b0, dreg};

  // Sequencing.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        if (sat) begin
          done <= 1'b1;
        end else begin
          busy <= 1'b1;
          cnt  <= 6'd47;
        end
      end else if (busy) begin
        cnt <= cnt - 6'd1;
        if (cnt == 6'd0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Remainder and quotient shifting.
  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= 48'(numer[65:48]);
      nlo  <= numer[47:0];
      dreg <= denom;
      quot <= sat ? mcrm_pkg::MAX48 : '0;
    end else if (busy) begin
      rem  <= fits ? 48'(trial - {1'b0, dreg}) : trial[47:0];
      quot <= {quot[46:0], fits};
      nlo  <= {nlo[46:0], 1'b0};
    end
  end

  `ASSERT_IMPLIES(a_div_start_idle, clk, rst, start, !busy)
  `ASSERT_NEXT(a_div_start_runs, clk, rst, start, busy || done)

endmodule

`default_nettype wire

// ----- design/mcrm_datapath.sv -----
// ----------------------------------------------------------------------------
// mcrm_datapath
// Tables, probability memory, shared multiplier, divider, accumulators and
// the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module mcrm_datapath (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire mcrm_pkg::in_item_t  in_data,
  input  wire mcrm_pkg::cmd_t      cmd,
  output mcrm_pkg::sts_t           sts,
  input  wire logic                out_ready,
  output logic                     out_valid,
  output mcrm_pkg::out_item_t      out_data
);

  // Probability memory with per-entry valid bits.
  logic [31:0]                     mem [mcrm_pkg::MEM_DEPTH];
  logic [mcrm_pkg::MEM_DEPTH-1:0]  mem_vld;
  logic [31:0]                     rd_data;
  logic                            rd_vld;
  logic                            rd_diag;
  logic [31:0]                     pval;

  // Per-population tables.
  logic [31:0] size_tab  [mcrm_pkg::POPULATIONS];
  logic [31:0] dens_tab  [mcrm_pkg::POPULATIONS];
  logic [47:0] mixed_tab [mcrm_pkg::POPULATIONS];
  logic [47:0] max_tab   [mcrm_pkg::POPULATIONS];

  // Arithmetic registers.
  logic [mcrm_pkg::SUM_W-1:0] sum;
  logic [31:0] op_a;
  logic [63:0] pp;
  logic [63:0] prod;
  logic [63:0] prod_hi;
  logic [65:0] num;
  logic [47:0] acc;
  logic [47:0] eff_hold;
  logic        fault;

  logic        src_ok;
  logic        tgt_ok;
  mcrm_pkg::idx_t src_idx;
  mcrm_pkg::idx_t tgt_idx;
  logic        wr_en;
  logic [mcrm_pkg::ADDR_W-1:0] wr_addr;
  logic [31:0] wr_data;
  logic        diag_over;
  logic [31:0] diag_val;
  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [63:0] mul_out;
  logic [95:0] wide;
  logic [49:0] mix_sum;
  logic [48:0] term_sum;
  logic        div_done;
  logic [47:0] quot;

  // Load index checks.
  assign src_ok  = 4'(in_data.source_index) < 4'(mcrm_pkg::POPULATIONS);
  assign tgt_ok  = 4'(in_data.target_index) < 4'(mcrm_pkg::POPULATIONS);
  assign src_idx = mcrm_pkg::idx_t'(in_data.source_index);
  assign tgt_idx = mcrm_pkg::idx_t'(in_data.target_index);

  // Diagonal is one minus the off-diagonal sum, clamped at zero.
  assign diag_over = sum > mcrm_pkg::SUM_ONE;
  assign diag_val  = diag_over ? '0 : 32'(mcrm_pkg::SUM_ONE - sum);

  // Memory write port is shared by loads and diagonal updates.
  assign wr_en   = (cmd.load_prob && src_ok && tgt_ok) || cmd.diag_write;
  assign wr_addr = cmd.diag_write ? {cmd.row, cmd.row} : {src_idx, tgt_idx};
  assign wr_data = cmd.diag_write ? diag_val : in_data.probability;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.rd_en) begin
      rd_data <= mem[{cmd.row, cmd.col}];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mem_vld <= '0;
      rd_vld  <= 1'b0;
      rd_diag <= 1'b0;
    end else begin
      if (wr_en) begin
        mem_vld[wr_addr] <= 1'b1;
      end
      if (cmd.rd_en) begin
        rd_vld  <= mem_vld[{cmd.row, cmd.col}];
        rd_diag <= cmd.row == cmd.col;
      end
    end
  end

  // An entry never written reads as its reset value.
  assign pval = rd_vld ? rd_data : (rd_diag ? mcrm_pkg::PROB_ONE : mcrm_pkg::PROB_DEFAULT);

  // Population record tables.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < mcrm_pkg::POPULATIONS; i++) begin
        size_tab[i] <= mcrm_pkg::SIZE_DEFAULT;
      end
    end else if (cmd.load_pop && src_ok) begin
      size_tab[src_idx] <= in_data.pop_size;
    end
  end

  // Densities start at zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < mcrm_pkg::POPULATIONS; i++) begin
        dens_tab[i] <= '0;
      end
    end else if (cmd.load_pop && src_ok) begin
      dens_tab[src_idx] <= in_data.contact_density;
    end
  end

  // Mixed sizes and per-target maxima.
  always_ff @(posedge clk) begin
    if (cmd.store_mix) begin
      mixed_tab[cmd.k] <= acc;
      max_tab[cmd.k]   <= '0;
    end else if (cmd.max_update && (acc > max_tab[cmd.k])) begin
      max_tab[cmd.k] <= acc;
    end
  end

  // Shared 32x32 multiplier with operand selection.
  always_comb begin
    priority if (cmd.mul_size) begin
      mul_a = pval;
      mul_b = size_tab[cmd.k];
    end else if (cmd.mul_pp) begin
      mul_a = op_a;
      mul_b = pval;
    end else if (cmd.mul_lo) begin
      mul_a = pp[31:0];
      mul_b = dens_tab[cmd.k];
    end else begin
      mul_a = pp[63:32];
      mul_b = dens_tab[cmd.k];
    end
  end

  assign mul_out = {32'b0, mul_a} * {32'b0, mul_b};
  assign wide    = {prod_hi, 32'b0} + {32'b0, prod};

  always_ff @(posedge clk) begin
    if (cmd.capture_a) begin
      op_a <= pval;
    end
    if (cmd.mul_pp) begin
      pp <= mul_out;
    end
    if (cmd.mul_size || cmd.mul_lo) begin
      prod <= mul_out;
    end
    if (cmd.mul_hi) begin
      prod_hi <= mul_out;
    end
    if (cmd.form_num) begin
      num <= wide[95:30];
    end
    if (cmd.hold_eff) begin
      eff_hold <= acc;
    end
  end

  mcrm_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .numer (num),
    .denom (mixed_tab[cmd.k]),
    .done  (div_done),
    .quot  (quot)
  );

  // Saturating sums.
  assign mix_sum  = 50'(acc) + 50'(prod[63:15]);
  assign term_sum = 49'(acc) + 49'(quot);

  // Accumulators and the run fault flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      sum   <= '0;
      acc   <= '0;
      fault <= 1'b0;
    end else begin
      if (cmd.run_start) begin
        sum   <= '0;
        acc   <= '0;
        fault <= 1'b0;
      end else begin
        if (cmd.sum_add) begin
          sum <= sum + mcrm_pkg::SUM_W'(pval);
        end
        if (cmd.diag_write) begin
          sum <= '0;
          if (diag_over) begin
            fault <= 1'b1;
          end
        end
        if (cmd.store_mix && (acc == '0)) begin
          fault <= 1'b1;
        end
        if (cmd.acc_clear) begin
          acc <= '0;
        end else if (cmd.acc_mix) begin
          acc <= (mix_sum > 50'(mcrm_pkg::MAX48)) ? mcrm_pkg::MAX48 : mix_sum[47:0];
        end else if (cmd.acc_term) begin
          acc <= (term_sum > 49'(mcrm_pkg::MAX48)) ? mcrm_pkg::MAX48 : term_sum[47:0];
        end
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_data.row_index               <= 2'(cmd.row);
      out_data.column_index            <= 2'(cmd.col);
      out_data.effective_rate          <= eff_hold;
      out_data.multiplier_rate         <= acc;
      out_data.actual_size_of_target   <= mixed_tab[cmd.k];
      out_data.max_effective_of_target <= max_tab[cmd.k];
      out_data.fault                   <= fault;
      out_data.last                    <= cmd.last;
    end
  end

  // Status back to the controller.
  assign sts.mixed_zero = mixed_tab[cmd.k] == '0;
  assign sts.div_done   = div_done;
  assign sts.out_free   = !out_valid || out_ready;

endmodule

`default_nettype wire

// ----- design/mcrm_ctrl.sv -----
// ----------------------------------------------------------------------------
// mcrm_ctrl
// Sequencer that walks the diagonal, mixed-size and rate passes of a compute.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module mcrm_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  input  wire logic [1:0]     opcode,
  output logic                in_ready,
  output mcrm_pkg::cmd_t      cmd,
  input  wire mcrm_pkg::sts_t sts
);

  localparam mcrm_pkg::idx_t LAST = mcrm_pkg::idx_t'(mcrm_pkg::POPULATIONS - 1);

  mcrm_pkg::state_t state, state_next;
  mcrm_pkg::idx_t   s, s_next;
  mcrm_pkg::idx_t   t, t_next;
  mcrm_pkg::idx_t   m, m_next;
  logic             mult_mode, mult_mode_next;
  logic             emit_pass, emit_pass_next;

  // State and loop counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= mcrm_pkg::ST_IDLE;
      s         <= '0;
      t         <= '0;
      m         <= '0;
      mult_mode <= 1'b0;
      emit_pass <= 1'b0;
    end else begin
      state     <= state_next;
      s         <= s_next;
      t         <= t_next;
      m         <= m_next;
      mult_mode <= mult_mode_next;
      emit_pass <= emit_pass_next;
    end
  end

  // Next state and commands.
  always_comb begin
    state_next     = state;
    s_next         = s;
    t_next         = t;
    m_next         = m;
    mult_mode_next = mult_mode;
    emit_pass_next = emit_pass;
    in_ready       = 1'b0;
    cmd            = '0;
    cmd.row        = s;
    cmd.col        = mult_mode ? t : m;
    cmd.k          = mult_mode ? t : m;

    unique case (state)
      mcrm_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          unique case (opcode)
            mcrm_pkg::OP_LOAD_PROB: cmd.load_prob = 1'b1;
            mcrm_pkg::OP_LOAD_POP:  cmd.load_pop = 1'b1;
            mcrm_pkg::OP_COMPUTE: begin
              cmd.run_start  = 1'b1;
              s_next         = '0;
              t_next         = '0;
              m_next         = '0;
              mult_mode_next = 1'b0;
              emit_pass_next = 1'b0;
              state_next     = mcrm_pkg::ST_DG_RD;
            end
            default: ;
          endcase
        end
      end

      // Row sums and diagonal rebuild.
      mcrm_pkg::ST_DG_RD: begin
        cmd.rd_en  = 1'b1;
        cmd.row    = s;
        cmd.col    = t;
        state_next = mcrm_pkg::ST_DG_ACC;
      end
      mcrm_pkg::ST_DG_ACC: begin
        cmd.sum_add = t != s;
        if (t == LAST) begin
          t_next     = '0;
          state_next = mcrm_pkg::ST_DG_WR;
        end else begin
          t_next     = t + 1'b1;
          state_next = mcrm_pkg::ST_DG_RD;
        end
      end
      mcrm_pkg::ST_DG_WR: begin
        cmd.diag_write = 1'b1;
        cmd.row        = s;
        if (s == LAST) begin
          s_next     = '0;
          t_next     = '0;
          m_next     = '0;
          state_next = mcrm_pkg::ST_MX_RD;
        end else begin
          s_next     = s + 1'b1;
          state_next = mcrm_pkg::ST_DG_RD;
        end
      end

      // Mixed sizes: column-weighted sums of head counts.
      mcrm_pkg::ST_MX_RD: begin
        cmd.rd_en  = 1'b1;
        cmd.row    = t;
        cmd.col    = m;
        state_next = mcrm_pkg::ST_MX_MUL;
      end
      mcrm_pkg::ST_MX_MUL: begin
        cmd.mul_size = 1'b1;
        cmd.k        = t;
        state_next   = mcrm_pkg::ST_MX_ACC;
      end
      mcrm_pkg::ST_MX_ACC: begin
        cmd.acc_mix = 1'b1;
        if (t == LAST) begin
          t_next     = '0;
          state_next = mcrm_pkg::ST_MX_ST;
        end else begin
          t_next     = t + 1'b1;
          state_next = mcrm_pkg::ST_MX_RD;
        end
      end
      mcrm_pkg::ST_MX_ST: begin
        cmd.store_mix = 1'b1;
        cmd.acc_clear = 1'b1;
        cmd.k         = m;
        if (m == LAST) begin
          m_next     = '0;
          s_next     = '0;
          t_next     = '0;
          state_next = mcrm_pkg::ST_PAIR;
        end else begin
          m_next     = m + 1'b1;
          state_next = mcrm_pkg::ST_MX_RD;
        end
      end

      // One source and target pair.
      mcrm_pkg::ST_PAIR: begin
        if (s == t) begin
          state_next = mcrm_pkg::ST_PAIR_END;
        end else begin
          m_next     = '0;
          state_next = mcrm_pkg::ST_TM_CHK;
        end
      end

      // One rate term: two probabilities, density, divide by mixed size.
      mcrm_pkg::ST_TM_CHK: begin
        if (sts.mixed_zero) begin
          state_next = mult_mode ? mcrm_pkg::ST_EMIT : mcrm_pkg::ST_TM_NEXT;
        end else begin
          state_next = mcrm_pkg::ST_TM_RD1;
        end
      end
      mcrm_pkg::ST_TM_RD1: begin
        cmd.rd_en  = 1'b1;
        cmd.row    = s;
        state_next = mcrm_pkg::ST_TM_RD2;
      end
      mcrm_pkg::ST_TM_RD2: begin
        cmd.rd_en     = 1'b1;
        cmd.row       = mult_mode ? s : t;
        cmd.capture_a = 1'b1;
        state_next    = mcrm_pkg::ST_TM_PP;
      end
      mcrm_pkg::ST_TM_PP: begin
        cmd.mul_pp = 1'b1;
        state_next = mcrm_pkg::ST_TM_LO;
      end
      mcrm_pkg::ST_TM_LO: begin
        cmd.mul_lo = 1'b1;
        state_next = mcrm_pkg::ST_TM_HI;
      end
      mcrm_pkg::ST_TM_HI: begin
        cmd.mul_hi = 1'b1;
        state_next = mcrm_pkg::ST_TM_NUM;
      end
      mcrm_pkg::ST_TM_NUM: begin
        cmd.form_num = 1'b1;
        state_next   = mcrm_pkg::ST_TM_DST;
      end
      mcrm_pkg::ST_TM_DST: begin
        cmd.div_start = 1'b1;
        state_next    = mcrm_pkg::ST_TM_DWAIT;
      end
      mcrm_pkg::ST_TM_DWAIT: begin
        if (sts.div_done) begin
          state_next = mcrm_pkg::ST_TM_ACC;
        end
      end
      mcrm_pkg::ST_TM_ACC: begin
        cmd.acc_term = 1'b1;
        state_next   = mult_mode ? mcrm_pkg::ST_EMIT : mcrm_pkg::ST_TM_NEXT;
      end
      mcrm_pkg::ST_TM_NEXT: begin
        if (m == LAST) begin
          state_next = mcrm_pkg::ST_PAIR_END;
        end else begin
          m_next     = m + 1'b1;
          state_next = mcrm_pkg::ST_TM_CHK;
        end
      end

      // First pass tracks maxima; second pass moves on to the multiplier term.
      mcrm_pkg::ST_PAIR_END: begin
        cmd.k = t;
        if (!emit_pass) begin
          cmd.max_update = 1'b1;
          state_next     = mcrm_pkg::ST_PAIR_NEXT;
        end else begin
          cmd.hold_eff   = 1'b1;
          cmd.acc_clear  = 1'b1;
          mult_mode_next = 1'b1;
          state_next     = mcrm_pkg::ST_TM_CHK;
        end
      end
      mcrm_pkg::ST_EMIT: begin
        cmd.row = s;
        cmd.col = t;
        cmd.k   = t;
        if (sts.out_free) begin
          cmd.emit   = 1'b1;
          cmd.last   = (s == LAST) && (t == LAST);
          state_next = mcrm_pkg::ST_PAIR_NEXT;
        end
      end
      mcrm_pkg::ST_PAIR_NEXT: begin
        cmd.acc_clear  = 1'b1;
        mult_mode_next = 1'b0;
        state_next     = mcrm_pkg::ST_PAIR;
        if (t == LAST) begin
          t_next = '0;
          if (s == LAST) begin
            s_next = '0;
            if (emit_pass) begin
              state_next = mcrm_pkg::ST_IDLE;
            end else begin
              emit_pass_next = 1'b1;
            end
          end else begin
            s_next = s + 1'b1;
          end
        end else begin
          t_next = t + 1'b1;
        end
      end
      default: begin
        state_next = mcrm_pkg::ST_IDLE;
      end
    endcase
  end

  `ASSERT_IMPLIES(a_ctrl_div_nonzero, clk, rst, cmd.div_start, !sts.mixed_zero)
  `ASSERT_IMPLIES(a_ctrl_emit_free, clk, rst, cmd.emit, sts.out_free)

endmodule

`default_nettype wire

// ----- test/mcrm_rate_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcrm_rate_checker
// Watches both channels of the migration rate matrix, keeps its own copy of
// the probability, size and density tables, predicts the sixteen results of
// every compute request and compares each delivered result field by field.
// ----------------------------------------------------------------------------

module mcrm_rate_checker (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                in_ready,
  input  mcrm_pkg::in_item_t  in_data,
  input  logic                out_valid,
  input  logic                out_ready,
  input  mcrm_pkg::out_item_t out_data,
  output int                  failures,
  output int                  pending
);

  logic [31:0]         prob_tbl [mcrm_pkg::POPULATIONS][mcrm_pkg::POPULATIONS];
  logic [31:0]         size_tbl [mcrm_pkg::POPULATIONS];
  logic [31:0]         dens_tbl [mcrm_pkg::POPULATIONS];
  mcrm_pkg::out_item_t rate_queue [$];

  assign pending = rate_queue.size();

  // One line per mismatch; printing stops after a while but counting goes on.
  task automatic report(string what, logic [47:0] got, logic [47:0] want);
    if (failures < 30)
      $display("%0t ns: mismatch on %s: got %0h, expected %0h", $time, what, got, want);
    failures++;
  endtask

  // floor(pp * c / (2^30 * a)), saturated to 48 bits.
  function automatic logic [47:0] contact_term(logic [63:0] pp, logic [31:0] c,
                                               logic [47:0] a);
    logic [127:0] num;
    logic [127:0] den;
    logic [127:0] quo;
    num = 128'(pp) * 128'(c);
    den = 128'(a) << 30;
    quo = num / den;
    return (quo > 128'(mcrm_pkg::MAX48)) ? mcrm_pkg::MAX48 : quo[47:0];
  endfunction

  function automatic logic [47:0] add_sat(logic [47:0] a, logic [47:0] b);
    logic [48:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[48] ? mcrm_pkg::MAX48 : s[47:0];
  endfunction

  // Rebuild the diagonal, mix the sizes and queue all pair results.
  task automatic predict_compute();
    logic [47:0] mixed [mcrm_pkg::POPULATIONS];
    logic [47:0] eff [mcrm_pkg::POPULATIONS][mcrm_pkg::POPULATIONS];
    logic [47:0] peak [mcrm_pkg::POPULATIONS];
    logic [63:0] row_sum;
    logic [47:0] acc;
    logic        fault;
    mcrm_pkg::out_item_t r;
    fault = 1'b0;
    for (int s = 0; s < mcrm_pkg::POPULATIONS; s++) begin
      row_sum = '0;
      for (int t = 0; t < mcrm_pkg::POPULATIONS; t++)
        if (t != s) row_sum += 64'(prob_tbl[s][t]);
      if (row_sum > 64'(mcrm_pkg::PROB_ONE)) begin
        prob_tbl[s][s] = '0;
        fault = 1'b1;
      end else begin
        prob_tbl[s][s] = 32'(64'(mcrm_pkg::PROB_ONE) - row_sum);
      end
    end
    for (int m = 0; m < mcrm_pkg::POPULATIONS; m++) begin
      acc = '0;
      for (int t = 0; t < mcrm_pkg::POPULATIONS; t++)
        acc = add_sat(acc, 48'((64'(prob_tbl[t][m]) * 64'(size_tbl[t])) >> 15));
      mixed[m] = acc;
      if (acc == '0) fault = 1'b1;
      peak[m] = '0;
    end
    for (int s = 0; s < mcrm_pkg::POPULATIONS; s++)
      for (int t = 0; t < mcrm_pkg::POPULATIONS; t++) begin
        acc = '0;
        if (s != t) begin
          for (int m = 0; m < mcrm_pkg::POPULATIONS; m++)
            if (mixed[m] != '0)
              acc = add_sat(acc, contact_term(64'(prob_tbl[s][m]) * 64'(prob_tbl[t][m]),
                                              dens_tbl[m], mixed[m]));
          if (acc > peak[t]) peak[t] = acc;
        end
        eff[s][t] = acc;
      end
    for (int s = 0; s < mcrm_pkg::POPULATIONS; s++)
      for (int t = 0; t < mcrm_pkg::POPULATIONS; t++) begin
        r.row_index               = 2'(s);
        r.column_index            = 2'(t);
        r.effective_rate          = eff[s][t];
        r.multiplier_rate         = (mixed[t] == '0) ? '0 :
          contact_term(64'(prob_tbl[s][t]) * 64'(prob_tbl[s][t]), dens_tbl[t], mixed[t]);
        r.actual_size_of_target   = mixed[t];
        r.max_effective_of_target = peak[t];
        r.fault                   = fault;
        r.last                    = (s == mcrm_pkg::POPULATIONS - 1) &&
                                    (t == mcrm_pkg::POPULATIONS - 1);
        rate_queue.push_back(r);
      end
  endtask

  // Track accepted requests and delivered results.
  always @(posedge clk) begin
    mcrm_pkg::out_item_t want;
    if (rst) begin
      for (int s = 0; s < mcrm_pkg::POPULATIONS; s++) begin
        for (int t = 0; t < mcrm_pkg::POPULATIONS; t++)
          prob_tbl[s][t] = (s == t) ? mcrm_pkg::PROB_ONE : mcrm_pkg::PROB_DEFAULT;
        size_tbl[s] = mcrm_pkg::SIZE_DEFAULT;
        dens_tbl[s] = '0;
      end
      rate_queue.delete();
      failures = 0;
    end else begin
      if (in_valid && in_ready) begin
        case (in_data.opcode)
          mcrm_pkg::OP_LOAD_PROB:
            prob_tbl[in_data.source_index][in_data.target_index] = in_data.probability;
          mcrm_pkg::OP_LOAD_POP: begin
            size_tbl[in_data.source_index] = in_data.pop_size;
            dens_tbl[in_data.source_index] = in_data.contact_density;
          end
          mcrm_pkg::OP_COMPUTE: predict_compute();
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (rate_queue.size() == 0) begin
          report("unexpected result", 48'(out_data.row_index), 48'd0);
        end else begin
          want = rate_queue.pop_front();
          if (out_data.row_index != want.row_index)
            report("row_index", 48'(out_data.row_index), 48'(want.row_index));
          if (out_data.column_index != want.column_index)
            report("column_index", 48'(out_data.column_index), 48'(want.column_index));
          if (out_data.effective_rate != want.effective_rate)
            report("effective_rate", out_data.effective_rate, want.effective_rate);
          if (out_data.multiplier_rate != want.multiplier_rate)
            report("multiplier_rate", out_data.multiplier_rate, want.multiplier_rate);
          if (out_data.actual_size_of_target != want.actual_size_of_target)
            report("actual_size_of_target", out_data.actual_size_of_target,
                   want.actual_size_of_target);
          if (out_data.max_effective_of_target != want.max_effective_of_target)
            report("max_effective_of_target", out_data.max_effective_of_target,
                   want.max_effective_of_target);
          if (out_data.fault != want.fault)
            report("fault", 48'(out_data.fault), 48'(want.fault));
          if (out_data.last != want.last)
            report("last", 48'(out_data.last), 48'(want.last));
        end
      end
    end
  end

endmodule

// ----- test/tb_migration_contact_rate_matrix.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_migration_contact_rate_matrix
// Drives load and compute requests into the migration rate matrix with
// random gaps and output stalls, including one long output hold-off, and
// reports the verdict from the checker's failure count.
// ----------------------------------------------------------------------------

module tb_migration_contact_rate_matrix;

  localparam int RANDOM_ITEMS = 270;
  localparam int HOLD_CYCLES  = 600;

  logic                clk;
  logic                rst;
  logic                in_valid;
  logic                in_ready;
  mcrm_pkg::in_item_t  in_data;
  logic                out_valid;
  logic                out_ready;
  mcrm_pkg::out_item_t out_data;
  int                  failures;
  int                  pending;
  logic                in_fire;
  int                  phase;
  int                  hold_left;
  logic                hold_done;

  migration_contact_rate_matrix uut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  mcrm_rate_checker checker_i (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .failures (failures),
    .pending  (pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Hard limit on the whole run, well above a run made only of compute requests.
  initial begin
    #20_000_000;
    $display("migration_contact_rate_matrix verification failed");
    $finish;
  end

  // Remember whether the request on offer was taken at the last rising edge.
  always @(posedge clk) in_fire <= in_valid && in_ready;

  // Receiver: random stalls per phase, plus one long hold-off once results flow.
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (!hold_done && out_valid && phase == 1) begin
      out_ready <= 1'b0;
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (phase == 2) begin
      out_ready <= ($urandom_range(0, 99) >= 75);
    end else if (phase == 3) begin
      out_ready <= ($urandom_range(0, 99) >= 12);
    end else begin
      out_ready <= 1'b1;
    end
  end

  function automatic mcrm_pkg::in_item_t prob_req(int s, int t, logic [31:0] p);
    mcrm_pkg::in_item_t r;
    r = mcrm_pkg::in_item_t'({$urandom, $urandom, $urandom, $urandom});
    r.opcode = mcrm_pkg::OP_LOAD_PROB;
    r.source_index = 2'(s);
    r.target_index = 2'(t);
    r.probability = p;
    return r;
  endfunction

  function automatic mcrm_pkg::in_item_t pop_req(int i, logic [31:0] sz, logic [31:0] dens);
    mcrm_pkg::in_item_t r;
    r = mcrm_pkg::in_item_t'({$urandom, $urandom, $urandom, $urandom});
    r.opcode = mcrm_pkg::OP_LOAD_POP;
    r.source_index = 2'(i);
    r.pop_size = sz;
    r.contact_density = dens;
    return r;
  endfunction

  function automatic mcrm_pkg::in_item_t opcode_req(logic [1:0] op);
    mcrm_pkg::in_item_t r;
    r = mcrm_pkg::in_item_t'({$urandom, $urandom, $urandom, $urandom});
    r.opcode = op;
    return r;
  endfunction

  // Offer one request, with a random gap first, and wait until it is taken.
  task automatic send_req(mcrm_pkg::in_item_t r);
    int idle_pct;
    idle_pct = (phase == 1) ? 75 : (phase == 3) ? 12 : 0;
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= r;
    @(negedge clk);
    while (!in_fire) @(negedge clk);
  endtask

  // Mostly small probabilities so that rows stay under one.
  function automatic logic [31:0] rand_prob();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 3) return mcrm_pkg::PROB_ONE;
    if (pick < 80) return $urandom_range(0, 32'h1000_0000);
    return $urandom_range(0, 32'h8000_0000);
  endfunction

  function automatic logic [31:0] rand_size();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 8) return '0;
    if (pick < 16) return '1;
    if (pick < 50) return $urandom_range(1, 1_000_000);
    return $urandom;
  endfunction

  initial begin
    int pick;
    rst      = 1'b1;
    in_valid = 1'b0;
    in_data  = '0;
    phase    = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: extreme records, saturation, diagonal write, overfull row,
    // ignored opcode and an all-zero mixed size.
    send_req(pop_req(0, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    send_req(pop_req(1, 32'd1, 32'd0));
    send_req(pop_req(2, mcrm_pkg::SIZE_DEFAULT, 32'h0001_0000));
    send_req(pop_req(3, 32'd0, 32'd12345));
    send_req(opcode_req(mcrm_pkg::OP_COMPUTE));
    send_req(prob_req(0, 1, mcrm_pkg::PROB_ONE));
    send_req(prob_req(0, 2, 32'd0));
    send_req(prob_req(3, 2, 32'h7FFF_FFFF));
    send_req(prob_req(1, 1, 32'h0000_1234));
    send_req(opcode_req(2'd3));
    send_req(opcode_req(mcrm_pkg::OP_COMPUTE));
    send_req(prob_req(0, 1, 32'd0));
    send_req(prob_req(3, 2, mcrm_pkg::PROB_DEFAULT));
    for (int i = 0; i < mcrm_pkg::POPULATIONS; i++)
      send_req(pop_req(i, 32'd0, $urandom));
    send_req(opcode_req(mcrm_pkg::OP_COMPUTE));
    for (int i = 0; i < mcrm_pkg::POPULATIONS; i++)
      send_req(pop_req(i, rand_size(), $urandom));
    send_req(opcode_req(mcrm_pkg::OP_COMPUTE));

    // Random traffic, switching the idle pattern every 64 requests.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      phase = (n / 64) % 4;
      pick = $urandom_range(0, 99);
      if (pick < 55)
        send_req(prob_req($urandom_range(0, 3), $urandom_range(0, 3), rand_prob()));
      else if (pick < 85)
        send_req(pop_req($urandom_range(0, 3), rand_size(), $urandom));
      else if (pick < 94)
        send_req(opcode_req(mcrm_pkg::OP_COMPUTE));
      else
        send_req(opcode_req(2'd3));
    end
    send_req(opcode_req(mcrm_pkg::OP_COMPUTE));
    in_valid <= 1'b0;
    phase = 0;

    // Drain, then allow for stray results.
    while (pending != 0) @(negedge clk);
    repeat (200) @(negedge clk);
    if (failures == 0)
      $display("migration_contact_rate_matrix verification clean");
    else
      $display("migration_contact_rate_matrix verification failed");
    $finish;
  end

endmodule
